// ===== rtl/core/blpg_pkg.sv =====
// ============================================================================
// blpg_pkg
// Shared widths and screen limits for the Bresenham line pixel generator.
// ============================================================================
package blpg_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;

    localparam int X_W   = 7;
    localparam int Y_W   = 6;
    localparam int ERR_W = 9;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_FIELDS_W  = 2 * X_W + 2 * Y_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * X_W + 2 * Y_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [X_W-1:0]          coord_x_t;
    typedef logic [Y_W-1:0]          coord_y_t;
    typedef logic signed [ERR_W-1:0] err_t;

endpackage

// ===== rtl/core/bresenham_line_pixel_generator.sv =====
// ============================================================================
// bresenham_line_pixel_generator
// Walks a Bresenham line between two screen endpoints and streams the
// pixels out two per beat.
// ============================================================================
// One input beat carries a line command; the block then emits ceil(n/2)
// output beats for a line of n = max(|dx|, |dy|) + 1 pixels, the last beat
// marked with tlast and its second pixel flagged invalid in tuser when n is
// odd. A single step unit (error update, compare and coordinate increment) is
// reused for every pixel, so each output beat passes through the states
// S_FIRST, S_SECOND and S_OUT in order and waits in S_OUT while the output
// is stalled; a final beat that holds a single pixel skips S_SECOND. The
// block takes no new command until the last beat of the current line has
// been accepted. Endpoints beyond the screen are saturated to its edge.
module bresenham_line_pixel_generator #(
    parameter int SCREEN_WIDTH  = blpg_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = blpg_pkg::SCREEN_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x[6:0], start_y[12:7], end_x[19:13], end_y[25:20], zero pad above
    input  logic [blpg_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // first_x[6:0], first_y[12:7], second_x[19:13], second_y[25:20],
    // zero pad above
    output logic [blpg_pkg::OUT_DATA_W-1:0] m_tdata,
    // second_valid
    output logic                           m_tuser,
    // final_result
    output logic                           m_tlast
);

    localparam int X_W     = blpg_pkg::X_W;
    localparam int Y_W     = blpg_pkg::Y_W;
    localparam int ERR_W   = blpg_pkg::ERR_W;
    localparam int E2_W    = ERR_W + 1;
    // Wide enough to hold a screen limit of 128.
    localparam int CLAMP_W = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND,
        S_OUT
    } state_t;

    state_t              state_reg;
    blpg_pkg::coord_x_t  cur_x_reg, tgt_x_reg, span_x_reg;
    blpg_pkg::coord_y_t  cur_y_reg, tgt_y_reg, span_y_reg;
    blpg_pkg::err_t      err_reg;
    logic                left_reg, up_reg;

    blpg_pkg::coord_x_t  first_x_reg, second_x_reg;
    blpg_pkg::coord_y_t  first_y_reg, second_y_reg;
    logic                second_valid_reg, final_reg;

    // Command decode with saturation to the screen edge.
    blpg_pkg::coord_x_t  in_x0, in_x1;
    blpg_pkg::coord_y_t  in_y0, in_y1;
    blpg_pkg::coord_x_t  x0, x1, dx;
    blpg_pkg::coord_y_t  y0, y1, dy;
    blpg_pkg::err_t      err_init;

    assign in_x0 = s_tdata[X_W-1:0];
    assign in_y0 = s_tdata[X_W+Y_W-1:X_W];
    assign in_x1 = s_tdata[2*X_W+Y_W-1:X_W+Y_W];
    assign in_y1 = s_tdata[2*X_W+2*Y_W-1:2*X_W+Y_W];

    always_comb
    begin
        x0 = ({{(CLAMP_W-X_W){1'b0}}, in_x0} >= CLAMP_W'(SCREEN_WIDTH))
             ? X_W'(SCREEN_WIDTH - 1) : in_x0;
        x1 = ({{(CLAMP_W-X_W){1'b0}}, in_x1} >= CLAMP_W'(SCREEN_WIDTH))
             ? X_W'(SCREEN_WIDTH - 1) : in_x1;
        y0 = ({{(CLAMP_W-Y_W){1'b0}}, in_y0} >= CLAMP_W'(SCREEN_HEIGHT))
             ? Y_W'(SCREEN_HEIGHT - 1) : in_y0;
        y1 = ({{(CLAMP_W-Y_W){1'b0}}, in_y1} >= CLAMP_W'(SCREEN_HEIGHT))
             ? Y_W'(SCREEN_HEIGHT - 1) : in_y1;
        dx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        dy = (y1 > y0) ? (y1 - y0) : (y0 - y1);
        err_init = ERR_W'(signed'({{(ERR_W-X_W){1'b0}}, dx})
                          - signed'({{(ERR_W-Y_W){1'b0}}, dy}));
    end

    // Shared step unit: one Bresenham move from the current pixel.
    logic signed [E2_W-1:0] e2, sx_ext, sy_ext, err_sum;
    logic                   move_x, move_y;
    blpg_pkg::coord_x_t     step_x;
    blpg_pkg::coord_y_t     step_y;
    blpg_pkg::err_t         step_err;
    logic                   at_target;

    always_comb
    begin
        e2      = signed'({err_reg, 1'b0});
        sx_ext  = signed'({{(E2_W-X_W){1'b0}}, span_x_reg});
        sy_ext  = signed'({{(E2_W-Y_W){1'b0}}, span_y_reg});
        move_x  = e2 > -sy_ext;
        move_y  = e2 < sx_ext;
        err_sum = E2_W'(err_reg) - (move_x ? sy_ext : '0) + (move_y ? sx_ext : '0);
        step_err = ERR_W'(err_sum);
        step_x  = move_x ? (left_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1) : cur_x_reg;
        step_y  = move_y ? (up_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1) : cur_y_reg;
        at_target = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            tgt_x_reg        <= '0;
            tgt_y_reg        <= '0;
            span_x_reg       <= '0;
            span_y_reg       <= '0;
            err_reg          <= '0;
            left_reg         <= 1'b0;
            up_reg           <= 1'b0;
            first_x_reg      <= '0;
            first_y_reg      <= '0;
            second_x_reg     <= '0;
            second_y_reg     <= '0;
            second_valid_reg <= 1'b0;
            final_reg        <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cur_x_reg  <= x0;
                        cur_y_reg  <= y0;
                        tgt_x_reg  <= x1;
                        tgt_y_reg  <= y1;
                        span_x_reg <= dx;
                        span_y_reg <= dy;
                        left_reg   <= !(x0 < x1);
                        up_reg     <= !(y0 < y1);
                        err_reg    <= err_init;
                        state_reg  <= S_FIRST;
                    end
                end
                S_FIRST:
                begin
                    first_x_reg <= cur_x_reg;
                    first_y_reg <= cur_y_reg;
                    if (at_target)
                    begin
                        // Odd pixel count: the second slot is empty.
                        second_x_reg     <= '0;
                        second_y_reg     <= '0;
                        second_valid_reg <= 1'b0;
                        final_reg        <= 1'b1;
                        state_reg        <= S_OUT;
                    end
                    else
                    begin
                        cur_x_reg <= step_x;
                        cur_y_reg <= step_y;
                        err_reg   <= step_err;
                        state_reg <= S_SECOND;
                    end
                end
                S_SECOND:
                begin
                    second_x_reg     <= cur_x_reg;
                    second_y_reg     <= cur_y_reg;
                    second_valid_reg <= 1'b1;
                    final_reg        <= at_target;
                    if (!at_target)
                    begin
                        cur_x_reg <= step_x;
                        cur_y_reg <= step_y;
                        err_reg   <= step_err;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= final_reg ? S_IDLE : S_FIRST;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tlast  = final_reg;
    assign m_tuser  = second_valid_reg;
    assign m_tdata  = {{(blpg_pkg::OUT_DATA_W - blpg_pkg::OUT_FIELDS_W){1'b0}},
                       second_y_reg, second_x_reg, first_y_reg, first_x_reg};

endmodule
